// ===== src/utf8d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, widths and status codes of the utf-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int OFFSET_WIDTH  = 32;
    localparam int BYTE_START_W  = 32;
    localparam int CP_W          = 21;
    localparam int LEN_W         = 3;
    localparam int STATUS_W      = 2;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [7:0]          t_byte;

    localparam t_status ST_CODE  = 2'd0;
    localparam t_status ST_END   = 2'd1;
    localparam t_status ST_SHORT = 2'd2;
    localparam t_status ST_ERROR = 2'd3;

    // one decoded item on its way from the front to the back
    typedef struct packed {
        t_status                 status;
        logic [3:0][7:0]         seq;
        logic [LEN_W-1:0]        len;
        logic [BYTE_START_W-1:0] byte_start;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qent;

endpackage
`default_nettype wire

// ===== src/utf8d_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_if
// Valid/ready channels of the decoder: byte input and result output.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface utf8d_out_if;
    import utf8d_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [CP_W-1:0]         code_point;
    logic [BYTE_START_W-1:0] byte_start;
    logic [LEN_W-1:0]        byte_length;

    modport source (output valid, output status, output code_point,
                    output byte_start, output byte_length, input ready);
    modport sink   (input valid, input status, input code_point,
                    input byte_start, input byte_length, output ready);
endinterface
`default_nettype wire

// ===== src/utf8d_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, tracks the open sequence, classifies each completed
// sequence as good or bad and pushes results into the queue.
// ----------------------------------------------------------------------------
module utf8d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utf8d_in_if.sink           i_in,
    input  logic               i_full,
    output utf8d_pkg::t_qent   o_push
);
    import utf8d_pkg::*;

    t_byte                   r_held [3];
    t_byte                   n_held [3];
    logic [1:0]              r_bh, n_bh;
    logic [LEN_W-1:0]        r_exp, n_exp;
    logic [OFFSET_WIDTH-1:0] r_offset, n_offset;
    logic                    r_err, n_err;

    logic                    fire;
    t_byte                   b;
    logic [LEN_W-1:0]        lead_len;
    logic [LEN_W-1:0]        fin_len;
    logic [3:0][7:0]         seq;
    logic                    seq_ok;

    function automatic logic [LEN_W-1:0] lead_length(input t_byte v);
        logic [LEN_W-1:0] l;
        priority if ((v & 8'h80) == 8'h00) l = 3'd1;
        else if ((v & 8'hE0) == 8'hC0)     l = 3'd2;
        else if ((v & 8'hF0) == 8'hE0)     l = 3'd3;
        else if ((v & 8'hF8) == 8'hF0)     l = 3'd4;
        else                               l = 3'd0;
        return l;
    endfunction

    // continuation bytes plus overlong and upper bound checks, done on bits
    function automatic logic seq_valid(input logic [LEN_W-1:0] len,
                                       input logic [3:0][7:0] s);
        logic c1, c2, c3, ok;
        c1 = (s[1][7:6] == 2'b10);
        c2 = (s[2][7:6] == 2'b10);
        c3 = (s[3][7:6] == 2'b10);
        unique case (len)
            3'd1: ok = 1'b1;
            3'd2: ok = c1 && (s[0][4:1] != 4'd0);
            3'd3: ok = c1 && c2 && ((s[0][3:0] != 4'd0) || s[1][5]);
            3'd4: ok = c1 && c2 && c3
                       && ((s[0][2:0] != 3'd0) || (s[1][5:4] != 2'd0))
                       && ((s[0][2:0] < 3'd4)
                           || ((s[0][2:0] == 3'd4) && (s[1][5:4] == 2'd0)));
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [BYTE_START_W-1:0] to_byte_start(
        input logic [OFFSET_WIDTH-1:0] off);
        logic [63:0] w;
        w = 64'(off);
        return w[BYTE_START_W-1:0];
    endfunction

    assign i_in.ready = !i_full;
    assign fire       = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign lead_len   = lead_length(b);
    assign fin_len    = (r_bh == 2'd0) ? lead_len : r_exp;

    // held bytes first, the current byte last
    always_comb begin
        seq[0] = (fin_len == 3'd1) ? b : r_held[0];
        seq[1] = (fin_len == 3'd2) ? b : r_held[1];
        seq[2] = (fin_len == 3'd3) ? b : r_held[2];
        seq[3] = b;
    end

    assign seq_ok = seq_valid(fin_len, seq);

    always_comb begin
        logic do_fail;
        logic do_finish;
        n_held   = r_held;
        n_bh     = r_bh;
        n_exp    = r_exp;
        n_offset = r_offset;
        n_err    = r_err;
        do_fail   = 1'b0;
        do_finish = 1'b0;
        o_push                 = '0;
        o_push.cmd.byte_start  = to_byte_start(r_offset);

        if (fire && !r_err) begin
            if (i_in.mode) begin
                o_push.valid      = 1'b1;
                o_push.cmd.status = (r_bh == 2'd0) ? ST_END : ST_SHORT;
            end else if (r_bh == 2'd0) begin
                if (lead_len == 3'd0) begin
                    do_fail = 1'b1;
                end else if (lead_len == 3'd1) begin
                    do_finish = 1'b1;
                end else begin
                    n_held[0] = b;
                    n_bh      = 2'd1;
                    n_exp     = lead_len;
                end
            end else begin
                if (r_exp < 3'd2 || r_exp > 3'd4 || {1'b0, r_bh} >= r_exp) begin
                    do_fail = 1'b1;
                end else if ({1'b0, r_bh} + 3'd1 == r_exp) begin
                    do_finish = 1'b1;
                end else begin
                    n_held[r_bh] = b;
                    n_bh         = r_bh + 2'd1;
                end
            end

            if (do_finish && !seq_ok) begin
                do_fail = 1'b1;
            end else if (do_finish) begin
                o_push.valid      = 1'b1;
                o_push.cmd.status = ST_CODE;
                o_push.cmd.seq    = seq;
                o_push.cmd.len    = fin_len;
                n_offset          = r_offset + OFFSET_WIDTH'(fin_len);
                n_bh              = 2'd0;
                n_exp             = '0;
            end

            if (do_fail) begin
                o_push.valid      = 1'b1;
                o_push.cmd.status = ST_ERROR;
                n_err             = 1'b1;
                n_bh              = 2'd0;
                n_exp             = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (!i_rst_n) begin
            r_bh     <= 2'd0;
            r_exp    <= '0;
            r_offset <= '0;
            r_err    <= 1'b0;
        end else begin
            r_bh     <= n_bh;
            r_exp    <= n_exp;
            r_offset <= n_offset;
            r_err    <= n_err;
        end
    end

    // once an error is latched the front goes silent
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_push.valid)
        else $error("result pushed after latched error");

endmodule
`default_nettype wire

// ===== src/utf8d_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_queue
// Short queue between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module utf8d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utf8d_pkg::t_qent  i_push,
    input  logic              i_pop,
    output utf8d_pkg::t_qent  o_head,
    output logic              o_full
);
    import utf8d_pkg::*;

    t_cmd                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, n_wr;
    logic [QUEUE_AW-1:0]   r_rd, n_rd;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign do_push = i_push.valid;
    assign do_pop  = i_pop && (r_count != '0);
    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_count != QUEUE_CW'(QUEUE_DEPTH)))
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== src/utf8d_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// Pops classified items, assembles the code point and holds the result
// in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module utf8d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utf8d_pkg::t_qent  i_head,
    output logic              o_pop,
    utf8d_out_if.source       o_out
);
    import utf8d_pkg::*;

    logic                    r_valid;
    t_status                 r_status;
    logic [CP_W-1:0]         r_cp;
    logic [BYTE_START_W-1:0] r_start;
    logic [LEN_W-1:0]        r_len;
    logic [CP_W-1:0]         n_cp;

    function automatic logic [CP_W-1:0] assemble(input logic [LEN_W-1:0] len,
                                                 input logic [3:0][7:0] s);
        logic [CP_W-1:0] cp;
        unique case (len)
            3'd1:    cp = {13'd0, s[0]};
            3'd2:    cp = {10'd0, s[0][4:0], s[1][5:0]};
            3'd3:    cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            3'd4:    cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
            default: cp = '0;
        endcase
        return cp;
    endfunction

    assign o_pop = i_head.valid && (!r_valid || o_out.ready);
    assign n_cp  = (i_head.cmd.status == ST_CODE)
                   ? assemble(i_head.cmd.len, i_head.cmd.seq) : '0;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_head.cmd.status;
            r_cp     <= n_cp;
            r_start  <= i_head.cmd.byte_start;
            r_len    <= (i_head.cmd.status == ST_CODE) ? i_head.cmd.len : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.code_point  = r_cp;
    assign o_out.byte_start  = r_start;
    assign o_out.byte_length = r_len;

    // a code point result always carries a sequence length
    a_code_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_CODE) |-> (r_len != '0 && r_len <= 3'd4))
        else $error("code point result with bad length");

endmodule
`default_nettype wire

// ===== src/utf8_code_point_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_code_point_decoder
// Byte-stream utf-8 decoder: front classifier, two-entry queue, back end
// that assembles code points into a registered output.
// ----------------------------------------------------------------------------
// a completed result is written into a queue entry and then into the output register
// throughput: one byte per cycle while the queue is not full
// the two-entry queue lets the front keep taking bytes while a result waits
// reset (synchronous, active low) clears sequence state, offset, error latch
// and queue pointers; no clearing pass is needed
// ----------------------------------------------------------------------------
module utf8_code_point_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8d_in_if.sink      i_in,
    utf8d_out_if.source   o_out
);
    import utf8d_pkg::*;

    t_qent w_push;
    t_qent w_head;
    logic  w_pop;
    logic  w_full;

    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ===== tb/utf8_code_point_decoder_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_checker
// Watches the byte and result channels of the decoder, decodes every accepted
// item on its own and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    utf8d_in_if   i_byte_ch,
    utf8d_out_if  i_result_ch,
    input  logic  i_end_of_test,
    output int    o_fail_count,
    output int    o_pending
);
    import utf8d_pkg::*;

    localparam logic [CP_W-1:0] CP_MAX_1 = 21'h00007F;
    localparam logic [CP_W-1:0] CP_MIN_2 = 21'h000080;
    localparam logic [CP_W-1:0] CP_MAX_2 = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_MIN_3 = 21'h000800;
    localparam logic [CP_W-1:0] CP_MAX_3 = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_MIN_4 = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX_4 = 21'h10FFFF;
    localparam int              MAX_PRINTED = 40;

    typedef struct packed {
        t_status                 status;
        logic [CP_W-1:0]         code_point;
        logic [BYTE_START_W-1:0] byte_start;
        logic [LEN_W-1:0]        byte_length;
    } t_decoded;

    t_byte                   seq_bytes [3];
    logic [2:0]              seq_have = '0;
    logic [2:0]              seq_want = '0;
    logic [OFFSET_WIDTH-1:0] seq_offset = '0;
    logic                    sticky_error = 1'b0;
    t_decoded                awaited_results [$];
    int                      mismatch_total = 0;
    bit                      leftovers_done = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatch_total++;
        if (mismatch_total <= MAX_PRINTED) begin
            $display("[%0t] decoder mismatch: %s", $time, msg);
        end
    endtask

    function automatic int lead_byte_length(t_byte b);
        if (b[7] == 1'b0) return 1;
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    function automatic t_decoded result_at_offset(t_status st, logic [CP_W-1:0] cp,
                                                  logic [LEN_W-1:0] n);
        t_decoded r;
        r.status      = st;
        r.code_point  = cp;
        r.byte_start  = seq_offset[BYTE_START_W-1:0];
        r.byte_length = n;
        return r;
    endfunction

    // a decode error drops the open sequence and blocks the stream until reset
    function automatic t_decoded flag_error();
        sticky_error = 1'b1;
        seq_have     = '0;
        seq_want     = '0;
        return result_at_offset(ST_ERROR, '0, '0);
    endfunction

    function automatic t_decoded complete_seq(int n, t_byte last);
        t_byte           seq [4];
        logic [CP_W-1:0] cp;
        bit              in_range;
        t_decoded        r;
        for (int i = 0; i < n - 1; i++) seq[i] = seq_bytes[i];
        seq[n-1] = last;
        case (n)
            1:       cp = CP_W'(seq[0]);
            2:       cp = CP_W'(seq[0][4:0]);
            3:       cp = CP_W'(seq[0][3:0]);
            default: cp = CP_W'(seq[0][2:0]);
        endcase
        // continuation bytes are only looked at once the sequence is complete
        for (int i = 1; i < n; i++) begin
            if (seq[i][7:6] != 2'b10) return flag_error();
            cp = {cp[CP_W-7:0], seq[i][5:0]};
        end
        case (n)
            1:       in_range = cp <= CP_MAX_1;
            2:       in_range = cp >= CP_MIN_2 && cp <= CP_MAX_2;
            3:       in_range = cp >= CP_MIN_3 && cp <= CP_MAX_3;
            default: in_range = cp >= CP_MIN_4 && cp <= CP_MAX_4;
        endcase
        if (!in_range) return flag_error();
        r          = result_at_offset(ST_CODE, cp, LEN_W'(n));
        seq_offset = seq_offset + OFFSET_WIDTH'(n);
        seq_have   = '0;
        seq_want   = '0;
        return r;
    endfunction

    function automatic bit decode_stream_item(logic end_marker, t_byte b, output t_decoded r);
        int n;
        r = '0;
        if (sticky_error) return 1'b0;
        if (end_marker) begin
            // an open sequence stays open across a short read
            r = result_at_offset((seq_have == 0) ? ST_END : ST_SHORT, '0, '0);
            return 1'b1;
        end
        if (seq_have == 0) begin
            n = lead_byte_length(b);
            if (n == 0) begin
                r = flag_error();
            end else if (n == 1) begin
                r = complete_seq(1, b);
            end else begin
                seq_bytes[0] = b;
                seq_have     = 3'd1;
                seq_want     = 3'(n);
                return 1'b0;
            end
            return 1'b1;
        end
        n = int'(seq_want);
        if (n < 2 || n > 4 || seq_have >= seq_want) begin
            r = flag_error();
            return 1'b1;
        end
        if (seq_have + 3'd1 == seq_want) begin
            r = complete_seq(n, b);
            return 1'b1;
        end
        seq_bytes[seq_have[1:0]] = b;
        seq_have++;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_decoded want;
        t_decoded got;
        if (!i_rst_n) begin
            seq_have     = '0;
            seq_want     = '0;
            seq_offset   = '0;
            sticky_error = 1'b0;
        end else begin
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                if (decode_stream_item(i_byte_ch.mode, i_byte_ch.data_byte, want)) begin
                    awaited_results.push_back(want);
                end
            end
            if (i_result_ch.valid && i_result_ch.ready) begin
                got.status      = i_result_ch.status;
                got.code_point  = i_result_ch.code_point;
                got.byte_start  = i_result_ch.byte_start;
                got.byte_length = i_result_ch.byte_length;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result st %0d cp %h start %0d len %0d",
                        got.status, got.code_point, got.byte_start, got.byte_length));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.code_point !== want.code_point ||
                        got.byte_start !== want.byte_start ||
                        got.byte_length !== want.byte_length) begin
                        report_mismatch($sformatf(
                            {"got st %0d cp %h start %0d len %0d, ",
                             "want st %0d cp %h start %0d len %0d"},
                            got.status, got.code_point, got.byte_start, got.byte_length,
                            want.status, want.code_point, want.byte_start, want.byte_length));
                    end
                end
            end
            if (i_end_of_test && !leftovers_done) begin
                leftovers_done = 1'b1;
                if (awaited_results.size() != 0) begin
                    report_mismatch($sformatf("%0d results never came, oldest st %0d start %0d",
                        awaited_results.size(), awaited_results[0].status,
                        awaited_results[0].byte_start));
                    awaited_results.delete();
                end
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= awaited_results.size();
    end

endmodule
`default_nettype wire

// ===== tb/utf8_code_point_decoder_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_test
// Feeds the decoder well-formed utf-8 with random content, end markers and
// short reads, then one decode error and ignored bytes after it, with random
// gaps on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_test;
    import utf8d_pkg::*;

    localparam logic            MODE_DATA       = 1'b0;
    localparam logic            MODE_END        = 1'b1;
    localparam logic [CP_W-1:0] CP_MAX_1        = 21'h00007F;
    localparam logic [CP_W-1:0] CP_MIN_2        = 21'h000080;
    localparam logic [CP_W-1:0] CP_MAX_2        = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_MIN_3        = 21'h000800;
    localparam logic [CP_W-1:0] CP_MAX_3        = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_MIN_4        = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX_4        = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_TOP          = 21'h1FFFFF;
    localparam logic [CP_W-1:0] SURROGATE_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURROGATE_HI    = 21'h00DFFF;
    localparam int              RANDOM_ITEMS    = 410;
    localparam int              NOISE_ITEMS     = 15;
    localparam int              STALL_LIMIT     = 2000;
    localparam int              DRAIN_LIMIT     = 500;
    localparam int              TAIL_CYCLES     = 10;
    localparam int              HOLD_OFF_AT     = 150;
    localparam int              HOLD_OFF_CYCLES = 80;

    typedef enum int {
        ERR_BAD_LEAD,
        ERR_BAD_CONT,
        ERR_OVERLONG,
        ERR_TOO_BIG
    } t_fault;

    typedef struct packed {
        logic  mode;
        t_byte data;
    } t_stream_item;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         end_of_test = 1'b0;
    int           fail_count;
    int           pending;
    int           items_sent   = 0;
    int           quiet_cycles = 0;
    t_stream_item stream_items [$];

    utf8d_in_if  in_ch ();
    utf8d_out_if out_ch ();

    utf8_code_point_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf8_code_point_decoder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_ch     (in_ch),
        .i_result_ch   (out_ch),
        .i_end_of_test (end_of_test),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_item(logic mode, t_byte data);
        t_stream_item it;
        it.mode = mode;
        it.data = data;
        stream_items.push_back(it);
    endfunction

    // split k puts an end marker after the k-th byte of the sequence
    function automatic void push_code_point(logic [CP_W-1:0] cp, int n, int split);
        t_byte lead;
        case (n)
            1:       lead = 8'h00;
            2:       lead = 8'hC0;
            3:       lead = 8'hE0;
            default: lead = 8'hF0;
        endcase
        push_item(MODE_DATA, lead | t_byte'(cp >> (6 * (n - 1))));
        for (int i = 1; i < n; i++) begin
            if (i == split) push_item(MODE_END, t_byte'($urandom_range(0, 255)));
            push_item(MODE_DATA, 8'h80 | t_byte'((cp >> (6 * (n - 1 - i))) & 21'h3F));
        end
    endfunction

    function automatic logic [CP_W-1:0] pick_code_point(int n);
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        int              roll;
        case (n)
            1: begin lo = '0;       hi = CP_MAX_1; end
            2: begin lo = CP_MIN_2; hi = CP_MAX_2; end
            3: begin lo = CP_MIN_3; hi = CP_MAX_3; end
            default: begin lo = CP_MIN_4; hi = CP_MAX_4; end
        endcase
        roll = $urandom_range(0, 9);
        if (roll == 0) return lo;
        if (roll == 1) return hi;
        if (roll == 2 && n == 3) return CP_W'($urandom_range(SURROGATE_LO, SURROGATE_HI));
        return CP_W'($urandom_range(lo, hi));
    endfunction

    // mostly back to back, now and then a long gap
    function automatic int pick_gap(bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    initial begin
        int     roll;
        int     n;
        int     split;
        int     gap;
        int     drain;
        int     idx;
        int     directed_count;
        bit     calm;
        t_fault fault;

        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_DATA;
        in_ch.data_byte <= '0;

        // directed: end on an empty stream, range edges, surrogate, short reads
        push_item(MODE_END, 8'h5A);
        push_code_point('0, 1, 0);
        push_code_point(CP_MAX_1, 1, 0);
        push_code_point(CP_MIN_2, 2, 0);
        push_code_point(CP_MAX_2, 2, 0);
        push_code_point(CP_MIN_3, 3, 0);
        push_code_point(CP_MAX_3, 3, 0);
        push_code_point(CP_MIN_4, 4, 0);
        push_code_point(CP_MAX_4, 4, 3);
        push_code_point(SURROGATE_LO, 3, 1);
        directed_count = stream_items.size();

        while (stream_items.size() < directed_count + RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                push_item(MODE_END, t_byte'($urandom_range(0, 255)));
            end else begin
                roll = $urandom_range(0, 9);
                n = (roll < 3) ? 1 : (roll < 6) ? 2 : (roll < 8) ? 3 : 4;
                split = 0;
                if (n > 1 && $urandom_range(0, 9) == 0) split = $urandom_range(1, n - 1);
                push_code_point(pick_code_point(n), n, split);
            end
        end

        // one decode error at the end, since it holds until reset
        fault = t_fault'($urandom_range(0, 3));
        n = $urandom_range(2, 4);
        case (fault)
            ERR_BAD_LEAD: begin
                if ($urandom_range(0, 1) == 0) push_item(MODE_DATA, t_byte'($urandom_range(8'h80, 8'hBF)));
                else push_item(MODE_DATA, t_byte'($urandom_range(8'hF8, 8'hFF)));
            end
            ERR_BAD_CONT: begin
                push_code_point(pick_code_point(n), n, 0);
                idx = stream_items.size() - n + $urandom_range(1, n - 1);
                if ($urandom_range(0, 1) == 0) stream_items[idx].data = t_byte'($urandom_range(0, 8'h7F));
                else stream_items[idx].data = t_byte'($urandom_range(8'hC0, 8'hFF));
            end
            ERR_OVERLONG: begin
                case (n)
                    2:       push_code_point(CP_W'($urandom_range(0, CP_MIN_2 - 1)), n, 0);
                    3:       push_code_point(CP_W'($urandom_range(0, CP_MIN_3 - 1)), n, 0);
                    default: push_code_point(CP_W'($urandom_range(0, CP_MIN_4 - 1)), n, 0);
                endcase
            end
            default: push_code_point(CP_W'($urandom_range(CP_MAX_4 + 1, CP_TOP)), 4, 0);
        endcase
        // ignored once the error is latched
        repeat (NOISE_ITEMS) begin
            push_item(logic'($urandom_range(0, 1)), t_byte'($urandom_range(0, 255)));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        calm = 1'b0;
        foreach (stream_items[k]) begin
            if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = pick_gap(calm);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.mode      <= stream_items[k].mode;
            in_ch.data_byte <= stream_items[k].data;
            do @(posedge i_clk); while (!in_ch.ready);
            items_sent++;
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);

        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** utf8_code_point_decoder: PASSED **");
        end else begin
            $display("** utf8_code_point_decoder: FAILED **");
        end
        $finish;
    end

    // result side: random stalls, long ready runs, one long hold-off
    initial begin
        int run;
        int gap;
        bit held_off;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && items_sent >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
            repeat (run) @(posedge i_clk);
            gap = pick_gap(1'b0);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** utf8_code_point_decoder: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
`default_nettype wire
